/* hw/rtl/capc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cascaded altitude PI controller package
// Widths, request codes, status codes, register indexes and reset values
// shared by the controller RTL.
// ----------------------------------------------------------------------------
package capc_pkg;

   // field widths
   localparam int CFG_W   = 31;
   localparam int DATA_W  = 32;
   localparam int STEP_W  = 18;
   localparam int FUNC_W  = 2;
   localparam int STAT_W  = 2;
   localparam int INDEX_W = 3;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_INIT   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NOP    = 2'd3;

   // response status codes
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_BAD_STEP  = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOT_READY = 2'd2;
   localparam logic [STAT_W-1:0] ST_BAD_DATA  = 2'd3;

   // register indexes
   localparam logic [INDEX_W-1:0] CSR_DEADBAND     = 3'd0;
   localparam logic [INDEX_W-1:0] CSR_POS_GAIN     = 3'd1;
   localparam logic [INDEX_W-1:0] CSR_MAX_SPEED    = 3'd2;
   localparam logic [INDEX_W-1:0] CSR_VEL_KP       = 3'd3;
   localparam logic [INDEX_W-1:0] CSR_VEL_KI       = 3'd4;
   localparam logic [INDEX_W-1:0] CSR_INT_LIMIT    = 3'd5;
   localparam logic [INDEX_W-1:0] CSR_OUT_LIMIT    = 3'd6;

   // register reset values (Q16.16)
   localparam logic [CFG_W-1:0] ONE_Q16  = 31'd65536;
   localparam logic [CFG_W-1:0] ZERO_Q16 = 31'd0;

   // time step limits and integrator divide
   localparam logic [STEP_W-1:0] MAX_STEP_US = 18'd200000;
   localparam logic [20:0]       US_PER_S    = 21'd1000000;
   localparam int DIV_RADIX_BITS = 4;
   localparam int DIV_W          = 68;
   localparam int DIV_STEPS      = DIV_W / DIV_RADIX_BITS;
   localparam int CNT_W          = $clog2(DIV_STEPS);
   localparam int INC_W          = 46;

endpackage

/* hw/rtl/cascaded_altitude_pi_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cascaded altitude PI controller
// P altitude loop feeding a PI vertical velocity loop with a clamped,
// back-calculated integrator, Q16.16 fixed point, one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  ports                                  direction  handshake
//  req      func, altitudes, velocity, valid, dt   in         req_valid / req_stall
//  rsp      correction, status, saturated          out        rsp_valid / rsp_stall
//  csr      csr_write, csr_index, csr_wdata        in         write strobe only
//
//  An update that passes its checks makes five passes through the one 32x32
//  multiplier and runs the 17-step radix-16 divide by one million for the
//  integrator increment; no new request is taken until its response is taken
//  and the back-calculation step is done.
//  Commands and rejected updates respond in the cycle after acceptance.
//  Synchronous reset loads the register reset values and clears integrator and ready; no clearing pass.
//  req_stall stays high while an update runs or a response is not yet taken.
// ----------------------------------------------------------------------------
module cascaded_altitude_pi_controller
   import capc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [FUNC_W-1:0]         req_func,
   input  logic signed [DATA_W-1:0]  req_target_altitude,
   input  logic signed [DATA_W-1:0]  req_measured_altitude,
   input  logic signed [DATA_W-1:0]  req_vertical_velocity,
   input  logic                      req_measurement_valid,
   input  logic [STEP_W-1:0]         req_step_time_us,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [DATA_W-1:0]  rsp_correction,
   output logic [STAT_W-1:0]         rsp_status,
   output logic                      rsp_saturated,
   input  logic                      csr_write,
   input  logic [INDEX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]          csr_wdata
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DB   = 4'd1;
   localparam logic [3:0] S_MPG  = 4'd2;
   localparam logic [3:0] S_TV   = 4'd3;
   localparam logic [3:0] S_VE   = 4'd4;
   localparam logic [3:0] S_MKP  = 4'd5;
   localparam logic [3:0] S_MKI  = 4'd6;
   localparam logic [3:0] S_P    = 4'd7;
   localparam logic [3:0] S_MLO  = 4'd8;
   localparam logic [3:0] S_MHI  = 4'd9;
   localparam logic [3:0] S_SUM  = 4'd10;
   localparam logic [3:0] S_DIV  = 4'd11;
   localparam logic [3:0] S_INT  = 4'd12;
   localparam logic [3:0] S_OUT  = 4'd13;
   localparam logic [3:0] S_SAT  = 4'd14;
   localparam logic [3:0] S_BACK = 4'd15;

   // control state
   logic [3:0]              state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    ready_ff, ready_in;
   logic [DATA_W-1:0]       integ_ff, integ_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;

   // configuration
   logic [CFG_W-1:0]        deadband_ff, deadband_in;
   logic [CFG_W-1:0]        pos_gain_ff, pos_gain_in;
   logic [CFG_W-1:0]        max_speed_ff, max_speed_in;
   logic [CFG_W-1:0]        vel_kp_ff, vel_kp_in;
   logic [CFG_W-1:0]        vel_ki_ff, vel_ki_in;
   logic [CFG_W-1:0]        int_limit_ff, int_limit_in;
   logic [CFG_W-1:0]        out_limit_ff, out_limit_in;

   // datapath
   logic [DATA_W-1:0]       rsp_correction_ff, rsp_correction_in;
   logic [STAT_W-1:0]       rsp_status_ff, rsp_status_in;
   logic                    rsp_saturated_ff, rsp_saturated_in;
   logic [32:0]             err_ff, err_in;
   logic [DATA_W-1:0]       vel_ff, vel_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [31:0]             effm_ff, effm_in;
   logic [31:0]             tv_ff, tv_in;
   logic                    vneg_ff, vneg_in;
   logic [31:0]             vem_ff, vem_in;
   logic [47:0]             prop_ff, prop_in;
   logic [63:0]             prod_ff, prod_in;
   logic [62:0]             p_ff, p_in;
   logic [49:0]             lo_ff, lo_in;
   logic [DIV_W-1:0]        div_ff, div_in;
   logic [19:0]             rem_ff, rem_in;
   logic [48:0]             unc_ff, unc_in;
   logic [49:0]             back_ff, back_in;

   // shared multiplier operands
   logic [31:0]             mul_a, mul_b;
   logic                    req_accept;

   assign req_stall  = (state_ff != S_IDLE) || rsp_valid_ff;
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_correction = rsp_correction_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_saturated  = rsp_saturated_ff;

   always_comb begin
      unique case (state_ff)
         S_MPG: begin
            mul_a = effm_ff;
            mul_b = {1'b0, pos_gain_ff};
         end
         S_MKP: begin
            mul_a = vem_ff;
            mul_b = {1'b0, vel_kp_ff};
         end
         S_MKI: begin
            mul_a = vem_ff;
            mul_b = {1'b0, vel_ki_ff};
         end
         S_MLO: begin
            mul_a = p_ff[31:0];
            mul_b = {14'd0, step_ff};
         end
         S_MHI: begin
            mul_a = {1'b0, p_ff[62:32]};
            mul_b = {14'd0, step_ff};
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      logic [32:0] abs33;
      logic [47:0] scaled;
      logic [30:0] tvm;
      logic [32:0] ve33;
      logic [19:0] r;
      logic [20:0] trial;
      logic [DIV_RADIX_BITS-1:0] qd;
      logic [47:0] inc48;
      logic [47:0] sum48;
      logic [47:0] ilim48;
      logic [48:0] olim49;
      logic [48:0] outc49;
      logic [49:0] ilim50;
      logic [49:0] bclamp;
      logic        sat;

      state_in          = state_ff;
      rsp_valid_in      = rsp_valid_ff;
      ready_in          = ready_ff;
      integ_in          = integ_ff;
      cnt_in            = cnt_ff;
      rsp_correction_in = rsp_correction_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_saturated_in  = rsp_saturated_ff;
      err_in            = err_ff;
      vel_in            = vel_ff;
      step_in           = step_ff;
      effm_in           = effm_ff;
      tv_in             = tv_ff;
      vneg_in           = vneg_ff;
      vem_in            = vem_ff;
      prop_in           = prop_ff;
      p_in              = p_ff;
      lo_in             = lo_ff;
      div_in            = div_ff;
      rem_in            = rem_ff;
      unc_in            = unc_ff;
      back_in           = back_ff;

      deadband_in  = deadband_ff;
      pos_gain_in  = pos_gain_ff;
      max_speed_in = max_speed_ff;
      vel_kp_in    = vel_kp_ff;
      vel_ki_in    = vel_ki_ff;
      int_limit_in = int_limit_ff;
      out_limit_in = out_limit_ff;

      abs33  = 33'd0;
      scaled = 48'd0;
      tvm    = 31'd0;
      ve33   = 33'd0;
      r      = 20'd0;
      trial  = 21'd0;
      qd     = '0;
      inc48  = 48'd0;
      sum48  = 48'd0;
      ilim48 = {17'd0, int_limit_ff};
      olim49 = {18'd0, out_limit_ff};
      ilim50 = {19'd0, int_limit_ff};
      outc49 = 49'd0;
      bclamp = 50'd0;
      sat    = 1'b0;

      if (csr_write) begin
         unique case (csr_index)
            CSR_DEADBAND:  deadband_in  = csr_wdata;
            CSR_POS_GAIN:  pos_gain_in  = csr_wdata;
            CSR_MAX_SPEED: max_speed_in = csr_wdata;
            CSR_VEL_KP:    vel_kp_in    = csr_wdata;
            CSR_VEL_KI:    vel_ki_in    = csr_wdata;
            CSR_INT_LIMIT: int_limit_in = csr_wdata;
            CSR_OUT_LIMIT: out_limit_in = csr_wdata;
            default: ;
         endcase
      end

      // drop the response once it is taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               rsp_correction_in = '0;
               rsp_status_in     = ST_OK;
               rsp_saturated_in  = 1'b0;
               priority if (req_func == FUNC_INIT) begin
                  integ_in     = '0;
                  ready_in     = 1'b1;
                  rsp_valid_in = 1'b1;
               end else if (req_func == FUNC_CLEAR) begin
                  integ_in     = '0;
                  rsp_valid_in = 1'b1;
               end else if (req_func == FUNC_NOP) begin
                  rsp_valid_in = 1'b1;
               end else if (req_step_time_us == '0 ||
                            req_step_time_us > MAX_STEP_US) begin
                  rsp_status_in = ST_BAD_STEP;
                  rsp_valid_in  = 1'b1;
               end else if (!ready_ff) begin
                  rsp_status_in = ST_NOT_READY;
                  rsp_valid_in  = 1'b1;
               end else if (!req_measurement_valid) begin
                  rsp_status_in = ST_BAD_DATA;
                  rsp_valid_in  = 1'b1;
               end else begin
                  err_in   = {req_target_altitude[31], req_target_altitude} -
                             {req_measured_altitude[31], req_measured_altitude};
                  vel_in   = req_vertical_velocity;
                  step_in  = req_step_time_us;
                  state_in = S_DB;
               end
            end
         end
         S_DB: begin
            abs33 = err_ff[32] ? (33'd0 - err_ff) : err_ff;
            if (abs33[31:0] <= {1'b0, deadband_ff}) begin
               effm_in = 32'd0;
            end else begin
               effm_in = abs33[31:0] - {1'b0, deadband_ff};
            end
            state_in = S_MPG;
         end
         S_MPG: begin
            state_in = S_TV;
         end
         S_TV: begin
            scaled = prod_ff[63:16];
            tvm    = (scaled > {17'd0, max_speed_ff}) ? max_speed_ff : scaled[30:0];
            tv_in  = err_ff[32] ? (32'd0 - {1'b0, tvm}) : {1'b0, tvm};
            state_in = S_VE;
         end
         S_VE: begin
            ve33    = {tv_ff[31], tv_ff} - {vel_ff[31], vel_ff};
            abs33   = ve33[32] ? (33'd0 - ve33) : ve33;
            vneg_in = ve33[32];
            vem_in  = abs33[31:0];
            state_in = S_MKP;
         end
         S_MKP: begin
            state_in = S_MKI;
         end
         S_MKI: begin
            prop_in  = vneg_ff ? (48'd0 - {1'b0, prod_ff[62:16]}) : {1'b0, prod_ff[62:16]};
            state_in = S_P;
         end
         S_P: begin
            p_in     = prod_ff[62:0];
            state_in = S_MLO;
         end
         S_MLO: begin
            state_in = S_MHI;
         end
         S_MHI: begin
            lo_in    = prod_ff[49:0];
            state_in = S_SUM;
         end
         S_SUM: begin
            // (hi * 2^32 + lo) >> 16, exact
            div_in   = {3'd0, {prod_ff[48:0], 16'd0} + {31'd0, lo_ff[49:16]}};
            rem_in   = 20'd0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            r = rem_ff;
            for (int k = 0; k < DIV_RADIX_BITS; k++) begin
               trial = {r, div_ff[DIV_W-1-k]};
               if (trial >= US_PER_S) begin
                  trial                      = trial - US_PER_S;
                  qd[DIV_RADIX_BITS-1-k]     = 1'b1;
               end else begin
                  qd[DIV_RADIX_BITS-1-k]     = 1'b0;
               end
               r = trial[19:0];
            end
            rem_in = r;
            div_in = {div_ff[DIV_W-DIV_RADIX_BITS-1:0], qd};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_INT;
            end
         end
         S_INT: begin
            inc48 = {2'd0, div_ff[INC_W-1:0]};
            if (vneg_ff) begin
               inc48 = 48'd0 - inc48;
            end
            sum48 = {{16{integ_ff[31]}}, integ_ff} + inc48;
            priority if ($signed(sum48) > $signed(ilim48)) begin
               integ_in = ilim48[31:0];
            end else if ($signed(sum48) < -$signed(ilim48)) begin
               integ_in = 32'd0 - ilim48[31:0];
            end else begin
               integ_in = sum48[31:0];
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            unc_in   = {prop_ff[47], prop_ff} + {{17{integ_ff[31]}}, integ_ff};
            state_in = S_SAT;
         end
         S_SAT: begin
            priority if ($signed(unc_ff) > $signed(olim49)) begin
               outc49 = olim49;
               sat    = 1'b1;
            end else if ($signed(unc_ff) < -$signed(olim49)) begin
               outc49 = 49'd0 - olim49;
               sat    = 1'b1;
            end else begin
               outc49 = unc_ff;
               sat    = 1'b0;
            end
            rsp_correction_in = outc49[31:0];
            rsp_status_in     = ST_OK;
            rsp_saturated_in  = sat;
            rsp_valid_in      = 1'b1;
            back_in  = {{18{outc49[31]}}, outc49[31:0]} - {{2{prop_ff[47]}}, prop_ff};
            state_in = S_BACK;
         end
         S_BACK: begin
            // back-calculate the integrator on output saturation
            if (rsp_saturated_ff) begin
               priority if ($signed(back_ff) > $signed(ilim50)) begin
                  bclamp = ilim50;
               end else if ($signed(back_ff) < -$signed(ilim50)) begin
                  bclamp = 50'd0 - ilim50;
               end else begin
                  bclamp = back_ff;
               end
               integ_in = bclamp[31:0];
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ready_ff     <= 1'b0;
         integ_ff     <= '0;
         cnt_ff       <= '0;
         deadband_ff  <= ZERO_Q16;
         pos_gain_ff  <= ONE_Q16;
         max_speed_ff <= ONE_Q16;
         vel_kp_ff    <= ONE_Q16;
         vel_ki_ff    <= ZERO_Q16;
         int_limit_ff <= ZERO_Q16;
         out_limit_ff <= ZERO_Q16;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ready_ff     <= ready_in;
         integ_ff     <= integ_in;
         cnt_ff       <= cnt_in;
         deadband_ff  <= deadband_in;
         pos_gain_ff  <= pos_gain_in;
         max_speed_ff <= max_speed_in;
         vel_kp_ff    <= vel_kp_in;
         vel_ki_ff    <= vel_ki_in;
         int_limit_ff <= int_limit_in;
         out_limit_ff <= out_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_correction_ff <= rsp_correction_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_saturated_ff  <= rsp_saturated_in;
      err_ff            <= err_in;
      vel_ff            <= vel_in;
      step_ff           <= step_in;
      effm_ff           <= effm_in;
      tv_ff             <= tv_in;
      vneg_ff           <= vneg_in;
      vem_ff            <= vem_in;
      prop_ff           <= prop_in;
      prod_ff           <= prod_in;
      p_ff              <= p_in;
      lo_ff             <= lo_in;
      div_ff            <= div_in;
      rem_ff            <= rem_in;
      unc_ff            <= unc_in;
      back_ff           <= back_in;
   end

   // a response rises only after an accepted request or a finished update
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(req_accept) || $past(state_ff) == S_SAT))
      else $error("response without a request");

   // error responses carry no correction and no saturation flag
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |->
         (rsp_correction_ff == '0 && !rsp_saturated_ff))
      else $error("nonzero correction on error status");

   // a saturated correction sits exactly on the output limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_saturated_ff) |->
         (rsp_correction_ff == {1'b0, out_limit_ff} ||
          rsp_correction_ff == (32'd0 - {1'b0, out_limit_ff})))
      else $error("saturated correction off the limit");

   // the divide always runs its full length before the integrator update
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INT) |-> ($past(state_ff) == S_DIV &&
                               $past(cnt_ff) == CNT_W'(DIV_STEPS - 1)))
      else $error("integrator update before divide finished");

endmodule

/* tb/cascaded_altitude_pi_controller_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cascaded altitude PI controller testbench
// Drives altitude update and command requests, with random gaps on both sides.
// Predicts every response in Q16.16 fixed point and checks it in order.
// Starts with a directed pass over status codes, deadband edges, extreme
// fields and extreme settings, then runs random phases with varied gains.
// ----------------------------------------------------------------------------
module testbench;
   import capc_pkg::*;

   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic signed [DATA_W-1:0]  target;
      logic signed [DATA_W-1:0]  measured;
      logic signed [DATA_W-1:0]  velocity;
      logic                      meas_valid;
      logic [STEP_W-1:0]         step_us;
   } altitude_req_t;

   typedef struct packed {
      logic signed [DATA_W-1:0]  correction;
      logic [STAT_W-1:0]         status;
      logic                      saturated;
   } correction_rsp_t;

   typedef struct packed {
      logic [CFG_W-1:0] deadband;
      logic [CFG_W-1:0] pos_gain;
      logic [CFG_W-1:0] max_speed;
      logic [CFG_W-1:0] vel_kp;
      logic [CFG_W-1:0] vel_ki;
      logic [CFG_W-1:0] int_limit;
      logic [CFG_W-1:0] out_limit;
   } ctrl_settings_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [FUNC_W-1:0]        req_func = FUNC_NOP;
   logic signed [DATA_W-1:0] req_target_altitude = '0;
   logic signed [DATA_W-1:0] req_measured_altitude = '0;
   logic signed [DATA_W-1:0] req_vertical_velocity = '0;
   logic                     req_measurement_valid = 1'b0;
   logic [STEP_W-1:0]        req_step_time_us = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_correction;
   logic [STAT_W-1:0]        rsp_status;
   logic                     rsp_saturated;
   logic                     csr_write = 1'b0;
   logic [INDEX_W-1:0]       csr_index = CSR_DEADBAND;
   logic [CFG_W-1:0]         csr_wdata = '0;

   // controller state as predicted
   logic [CFG_W-1:0] cfg_regs [0:6];
   longint           integ_model;
   bit               ready_model;

   correction_rsp_t  pending_corrections [$];
   correction_rsp_t  want;
   int               failures = 0;
   bit               req_idling = 1'b1;
   bit               rsp_idling = 1'b1;

   cascaded_altitude_pi_controller dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- predictor
   function automatic bit [63:0] abs64(input longint x);
      return (x < 0) ? -x : x;
   endfunction

   function automatic longint apply_sign(input longint s, input bit [63:0] m);
      return (s < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint gain_q16(input longint x, input bit [63:0] gain);
      bit [63:0] p;
      p = abs64(x) * gain;
      return apply_sign(x, p >> 16);
   endfunction

   function automatic longint clamp_sym(input longint x, input longint lim);
      if (x < -lim) return -lim;
      if (x > lim) return lim;
      return x;
   endfunction

   function automatic correction_rsp_t predict_correction(input altitude_req_t r);
      correction_rsp_t rsp;
      longint          alt_err, eff_err, tgt_vel, vel_err, prop, total, out_v;
      bit [63:0]       err_mag, prod, inc;
      rsp = '0;
      rsp.status = ST_OK;
      case (r.func)
         FUNC_INIT: begin
            integ_model = 0;
            ready_model = 1'b1;
            return rsp;
         end
         FUNC_CLEAR: begin
            integ_model = 0;
            return rsp;
         end
         FUNC_NOP: return rsp;
         default: ;
      endcase
      if (r.step_us == 0 || r.step_us > MAX_STEP_US) rsp.status = ST_BAD_STEP;
      else if (!ready_model) rsp.status = ST_NOT_READY;
      else if (!r.meas_valid) rsp.status = ST_BAD_DATA;
      if (rsp.status != ST_OK) return rsp;

      alt_err = longint'(r.target) - longint'(r.measured);
      err_mag = abs64(alt_err);
      eff_err = (err_mag <= cfg_regs[CSR_DEADBAND]) ? 0 :
                apply_sign(alt_err, err_mag - cfg_regs[CSR_DEADBAND]);
      tgt_vel = clamp_sym(gain_q16(eff_err, cfg_regs[CSR_POS_GAIN]), cfg_regs[CSR_MAX_SPEED]);
      vel_err = tgt_vel - longint'(r.velocity);
      prop = gain_q16(vel_err, cfg_regs[CSR_VEL_KP]);

      // split the divide by one million to stay inside 64 bits
      prod = abs64(vel_err) * cfg_regs[CSR_VEL_KI];
      inc = ((prod / US_PER_S) * r.step_us + ((prod % US_PER_S) * r.step_us) / US_PER_S) >> 16;
      integ_model = clamp_sym(integ_model + apply_sign(vel_err, inc), cfg_regs[CSR_INT_LIMIT]);

      total = prop + integ_model;
      out_v = clamp_sym(total, cfg_regs[CSR_OUT_LIMIT]);
      rsp.saturated = (out_v != total);
      // back-calculate the integrator against the clamped output
      if (rsp.saturated) integ_model = clamp_sym(out_v - prop, cfg_regs[CSR_INT_LIMIT]);
      rsp.correction = out_v[DATA_W-1:0];
      return rsp;
   endfunction

   // ---------------------------------------------------------------- checking
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_corrections.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual %h/%0d/%0b",
                     $time, rsp_correction, rsp_status, rsp_saturated);
            failures++;
         end else begin
            want = pending_corrections.pop_front();
            if (rsp_correction !== want.correction) begin
               $display("%0t: correction mismatch: expected %h actual %h",
                        $time, want.correction, rsp_correction);
               failures++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch: expected %0d actual %0d",
                        $time, want.status, rsp_status);
               failures++;
            end
            if (rsp_saturated !== want.saturated) begin
               $display("%0t: saturated mismatch: expected %0b actual %0b",
                        $time, want.saturated, rsp_saturated);
               failures++;
            end
         end
      end
      rsp_stall <= !reset && rsp_idling && ($urandom_range(99) < 23);
   end

   // ---------------------------------------------------------------- driving
   task automatic send_request(input altitude_req_t r);
      while (req_idling && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_func              <= r.func;
      req_target_altitude   <= r.target;
      req_measured_altitude <= r.measured;
      req_vertical_velocity <= r.velocity;
      req_measurement_valid <= r.meas_valid;
      req_step_time_us      <= r.step_us;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_corrections.push_back(predict_correction(r));
   endtask

   // hold the request side until every response is back
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (pending_corrections.size() != 0) @(posedge clock);
   endtask

   task automatic csr_put(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      cfg_regs[idx] = value;
   endtask

   task automatic apply_settings(input ctrl_settings_t s);
      wait_results_drained();
      repeat (4) @(posedge clock);
      csr_put(CSR_DEADBAND,  s.deadband);
      csr_put(CSR_POS_GAIN,  s.pos_gain);
      csr_put(CSR_MAX_SPEED, s.max_speed);
      csr_put(CSR_VEL_KP,    s.vel_kp);
      csr_put(CSR_VEL_KI,    s.vel_ki);
      csr_put(CSR_INT_LIMIT, s.int_limit);
      csr_put(CSR_OUT_LIMIT, s.out_limit);
      csr_write <= 1'b0;
   endtask

   function automatic altitude_req_t update_req(input logic [DATA_W-1:0] target,
                                                input logic [DATA_W-1:0] measured,
                                                input logic [DATA_W-1:0] velocity,
                                                input logic meas_valid,
                                                input logic [STEP_W-1:0] step_us);
      altitude_req_t r;
      r.func       = FUNC_UPDATE;
      r.target     = target;
      r.measured   = measured;
      r.velocity   = velocity;
      r.meas_valid = meas_valid;
      r.step_us    = step_us;
      return r;
   endfunction

   // commands carry random payload, which the block must ignore
   function automatic altitude_req_t command_req(input logic [FUNC_W-1:0] func);
      altitude_req_t r;
      r = update_req($urandom, $urandom, $urandom, $urandom_range(1), $urandom);
      r.func = func;
      return r;
   endfunction

   // mostly sign-extended values of the given width, now and then the full range
   function automatic logic signed [DATA_W-1:0] random_wide(input int unsigned bits);
      logic [DATA_W-1:0] v;
      v = $urandom;
      if ($urandom_range(9) == 0) return v;
      return $signed(v << (DATA_W - bits)) >>> (DATA_W - bits);
   endfunction

   function automatic logic [CFG_W-1:0] random_setting(input int unsigned typical);
      case ($urandom_range(15))
         0: return ZERO_Q16;
         1: return {CFG_W{1'b1}};
         2: return CFG_W'($urandom);
         default: return CFG_W'($urandom_range(0, typical));
      endcase
   endfunction

   function automatic ctrl_settings_t random_settings();
      ctrl_settings_t s;
      s.deadband  = random_setting(2 * 65536);
      s.pos_gain  = random_setting(4 * 65536);
      s.max_speed = random_setting(5 * 65536);
      s.vel_kp    = random_setting(100 * 65536);
      s.vel_ki    = random_setting(1000 * 65536);
      s.int_limit = random_setting(200 * 65536);
      s.out_limit = random_setting(500 * 65536);
      return s;
   endfunction

   function automatic altitude_req_t random_request();
      altitude_req_t r;
      int unsigned   pick;
      pick = $urandom_range(99);
      r.func = (pick < 88) ? FUNC_UPDATE : (pick < 93) ? FUNC_INIT :
               (pick < 97) ? FUNC_CLEAR : FUNC_NOP;
      // keep the measurement near the target so the loops act in range
      r.target     = random_wide(24);
      r.measured   = r.target + random_wide(19);
      r.velocity   = random_wide(18);
      r.meas_valid = ($urandom_range(99) < 95);
      pick = $urandom_range(99);
      if (pick < 80) r.step_us = $urandom_range(1000, 20000);
      else if (pick < 94) r.step_us = $urandom_range(1, MAX_STEP_US);
      else if (pick < 97) r.step_us = '0;
      else r.step_us = $urandom_range(MAX_STEP_US + 1, 2**STEP_W - 1);
      return r;
   endfunction

   // ---------------------------------------------------------------- tests
   task automatic test_status_before_init();
      send_request(update_req(32'h0001_0000, 32'h0, 32'h0, 1'b1, 18'd5000));
      send_request(update_req(32'h0001_0000, 32'h0, 32'h0, 1'b1, 18'd0));
      send_request(update_req(32'h0001_0000, 32'h0, 32'h0, 1'b1, MAX_STEP_US + 18'd1));
      send_request(update_req(32'h0001_0000, 32'h0, 32'h0, 1'b0, {STEP_W{1'b1}}));
      send_request(update_req(32'h0001_0000, 32'h0, 32'h0, 1'b0, 18'd5000));
      send_request(command_req(FUNC_CLEAR));
      send_request(command_req(FUNC_NOP));
   endtask

   task automatic test_reset_settings();
      send_request(command_req(FUNC_INIT));
      send_request(update_req(32'h0003_0000, 32'h0001_8000, 32'hFFFF_0000, 1'b1, 18'd5000));
      send_request(update_req(32'h0, 32'h0, 32'h0, 1'b1, 18'd1));
      send_request(update_req(32'h0003_0000, 32'h0, 32'h0, 1'b0, 18'd5000));
      send_request(update_req(32'hFFFE_0000, 32'h0, 32'h0000_4000, 1'b1, MAX_STEP_US));
      send_request(update_req(32'h0, 32'h0, 32'h0, 1'b1, 18'd1));
   endtask

   task automatic test_field_extremes();
      ctrl_settings_t s;
      s.deadband  = 31'd65536;
      s.pos_gain  = 31'd131072;
      s.max_speed = 31'd196608;
      s.vel_kp    = 31'd3276800;
      s.vel_ki    = 31'd13107200;
      s.int_limit = 31'd6553600;
      s.out_limit = 31'd19660800;
      apply_settings(s);
      send_request(command_req(FUNC_INIT));
      // error exactly at the deadband, then one step past it
      send_request(update_req(32'h0001_0000, 32'h0, 32'h0, 1'b1, 18'd5000));
      send_request(update_req(32'h0001_0001, 32'h0, 32'h0, 1'b1, 18'd5000));
      send_request(update_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1, MAX_STEP_US));
      send_request(update_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
                              MAX_STEP_US));
      send_request(update_req(32'h0, 32'h0, 32'h8000_0000, 1'b1, 18'd1));
      send_request(command_req(FUNC_CLEAR));
      send_request(update_req(32'h0, 32'hFFF6_0000, 32'h0, 1'b1, MAX_STEP_US));
   endtask

   task automatic test_register_extremes();
      apply_settings('1);
      send_request(update_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1,
                              MAX_STEP_US));
      send_request(update_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
                              MAX_STEP_US));
      apply_settings('0);
      send_request(update_req(32'h0005_0000, 32'h0, 32'h0001_0000, 1'b1, 18'd5000));
   endtask

   task automatic test_random_phases();
      for (int phase = 0; phase < 10; phase++) begin
         apply_settings(random_settings());
         // one phase runs flat out on both sides
         req_idling = (phase != 4);
         rsp_idling = (phase != 4);
         send_request(command_req(FUNC_INIT));
         for (int n = 0; n < 50; n++) begin
            send_request(random_request());
            if ($urandom_range(39) == 0) wait_results_drained();
         end
      end
      req_idling = 1'b1;
      rsp_idling = 1'b1;
   endtask

   initial begin
      cfg_regs[CSR_DEADBAND]  = ZERO_Q16;
      cfg_regs[CSR_POS_GAIN]  = ONE_Q16;
      cfg_regs[CSR_MAX_SPEED] = ONE_Q16;
      cfg_regs[CSR_VEL_KP]    = ONE_Q16;
      cfg_regs[CSR_VEL_KI]    = ZERO_Q16;
      cfg_regs[CSR_INT_LIMIT] = ZERO_Q16;
      cfg_regs[CSR_OUT_LIMIT] = ZERO_Q16;
      integ_model = 0;
      ready_model = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_status_before_init();
      test_reset_settings();
      test_field_extremes();
      test_register_extremes();
      test_random_phases();

      wait_results_drained();
      repeat (40) @(posedge clock);
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/capc_pkg.sv
hw/rtl/cascaded_altitude_pi_controller.sv
tb/cascaded_altitude_pi_controller_tb.sv
